/* rtl/slpg_pkg.sv */
// ----------------------------------------------------------------------------
// slpg_pkg
// Types and constants shared by the status LED pattern generator modules.
// ----------------------------------------------------------------------------
package slpg_pkg;

	localparam int LEVEL_W    = 8;
	localparam int MODE_W     = 3;
	localparam int PIX_IDX_W  = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int REG_SEL_W  = 3;
	localparam int NUM_REGS   = 8;
	localparam int REC_PHASE_W = 4;
	localparam int MARQUEE_W  = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BREATHE_MIN  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BREATHE_MAX  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BREATHE_INC  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_BRIGHT = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLASH_BRIGHT = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REC_BRIGHT   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REC_DIM      = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FLASH_TICKS  = 4'd7;

	localparam logic [LEVEL_W-1:0] REG_RESET [NUM_REGS] = '{
		8'd8, 8'd128, 8'd8, 8'd64, 8'd255, 8'd128, 8'd8, 8'd5
	};

	localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TRACKING = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LOCK     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SEARCH   = 3'd3;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'hFF;
	localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 8'h00;
	localparam logic [LEVEL_W-1:0] MARQUEE_MID  = 8'd96;
	localparam logic [LEVEL_W-1:0] MARQUEE_TAIL = 8'd36;

	typedef struct packed {
		logic [LEVEL_W-1:0]   red;
		logic [LEVEL_W-1:0]   green;
		logic [LEVEL_W-1:0]   blue;
		logic [LEVEL_W-1:0]   bright;
		logic                 marquee;
		logic [PIX_IDX_W-1:0] h0;
		logic [PIX_IDX_W-1:0] a0;
		logic [PIX_IDX_W-1:0] b0;
		logic [PIX_IDX_W-1:0] h1;
		logic [PIX_IDX_W-1:0] a1;
		logic [PIX_IDX_W-1:0] b1;
	} slpg_tick_t;

endpackage

/* rtl/slpg_front.sv */
// ----------------------------------------------------------------------------
// slpg_front
// Holds the configuration registers and animation state, classifies each
// tick item and produces its frame descriptor.
// ----------------------------------------------------------------------------
module slpg_front #(
	parameter int CHAIN0_PIXELS = 8,
	parameter int CHAIN1_PIXELS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [slpg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [slpg_pkg::LEVEL_W-1:0]   cfg_data,
	input  logic                          accept,
	input  logic [slpg_pkg::MODE_W-1:0]    track_mode,
	input  logic                          recording_on,
	input  logic                          photo_event,
	output slpg_pkg::slpg_tick_t          tick
);
	import slpg_pkg::*;

	localparam logic [PIX_IDX_W-1:0] N0M1 = PIX_IDX_W'(CHAIN0_PIXELS - 1);
	localparam logic [PIX_IDX_W-1:0] N0M2 = PIX_IDX_W'(CHAIN0_PIXELS - 2);
	localparam logic [PIX_IDX_W-1:0] N1M1 = PIX_IDX_W'(CHAIN1_PIXELS - 1);
	localparam logic [PIX_IDX_W-1:0] N1M2 = PIX_IDX_W'(CHAIN1_PIXELS - 2);

	logic [LEVEL_W-1:0]     regs_q [NUM_REGS];
	logic [LEVEL_W-1:0]     breathe_level_q;
	logic                   breathe_rising_q;
	logic [LEVEL_W-1:0]     flash_q;
	logic [REC_PHASE_W-1:0] record_q;
	logic                   search_q;
	logic [MARQUEE_W-1:0]   marquee_q;
	logic [PIX_IDX_W-1:0]   m0_q;
	logic [PIX_IDX_W-1:0]   m1_q;

	logic [LEVEL_W-1:0]     r_min, r_max, r_inc, r_norm, r_fbright, r_rbright, r_rdim, r_fticks;
	logic [LEVEL_W-1:0]     cd;
	logic                   flash;
	logic [REC_PHASE_W-1:0] rec_next;
	logic                   search_next;
	logic [LEVEL_W:0]       up_sum;
	logic [LEVEL_W:0]       dn_lim;
	logic [PIX_IDX_W-1:0]   h1;

	assign r_min     = regs_q[REG_SEL_W'(REG_BREATHE_MIN)];
	assign r_max     = regs_q[REG_SEL_W'(REG_BREATHE_MAX)];
	assign r_inc     = regs_q[REG_SEL_W'(REG_BREATHE_INC)];
	assign r_norm    = regs_q[REG_SEL_W'(REG_NORMAL_BRIGHT)];
	assign r_fbright = regs_q[REG_SEL_W'(REG_FLASH_BRIGHT)];
	assign r_rbright = regs_q[REG_SEL_W'(REG_REC_BRIGHT)];
	assign r_rdim    = regs_q[REG_SEL_W'(REG_REC_DIM)];
	assign r_fticks  = regs_q[REG_SEL_W'(REG_FLASH_TICKS)];

	assign cd          = photo_event ? r_fticks : flash_q;
	assign flash       = (cd != LEVEL_OFF);
	assign rec_next    = record_q + REC_PHASE_W'(1);
	assign search_next = ~search_q;
	assign up_sum      = {1'b0, breathe_level_q} + {1'b0, r_inc};
	assign dn_lim      = {1'b0, r_min} + {1'b0, r_inc};
	assign h1          = N1M1 - m1_q;

	always_comb begin
		tick         = '0;
		tick.blue    = LEVEL_FULL;
		tick.bright  = breathe_level_q;
		tick.marquee = 1'b0;
		priority if (flash) begin
			tick.red    = LEVEL_FULL;
			tick.green  = LEVEL_FULL;
			tick.blue   = LEVEL_FULL;
			tick.bright = r_fbright;
		end else if (recording_on) begin
			tick.red  = LEVEL_FULL;
			tick.blue = LEVEL_OFF;
			if (rec_next <= REC_PHASE_W'(1) ||
			    (rec_next >= REC_PHASE_W'(4) && rec_next <= REC_PHASE_W'(5))) begin
				tick.bright = r_rbright;
			end else begin
				tick.bright = r_rdim;
			end
		end else begin
			unique case (track_mode)
				MODE_IDLE: begin
					tick.bright = breathe_level_q;
				end
				MODE_TRACKING: begin
					tick.blue    = LEVEL_OFF;
					tick.green   = LEVEL_FULL;
					tick.bright  = r_norm;
					tick.marquee = 1'b1;
				end
				MODE_LOCK: begin
					tick.blue   = LEVEL_OFF;
					tick.red    = LEVEL_FULL;
					tick.green  = LEVEL_FULL;
					tick.bright = r_norm;
				end
				MODE_SEARCH: begin
					tick.blue   = LEVEL_OFF;
					tick.red    = LEVEL_FULL;
					tick.bright = search_next ? r_norm : r_min;
				end
				default: begin
					tick.bright = r_norm;
				end
			endcase
		end
		tick.h0 = m0_q;
		tick.a0 = (m0_q == '0) ? N0M1 : m0_q - PIX_IDX_W'(1);
		tick.b0 = (m0_q >= PIX_IDX_W'(2)) ? m0_q - PIX_IDX_W'(2) : m0_q + N0M2;
		tick.h1 = h1;
		tick.a1 = (h1 == N1M1) ? '0 : h1 + PIX_IDX_W'(1);
		tick.b1 = (h1 >= N1M2) ? h1 - N1M2 : h1 + PIX_IDX_W'(2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= REG_RESET[i];
			end
		end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
			regs_q[cfg_index[REG_SEL_W-1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			breathe_level_q  <= REG_RESET[0];
			breathe_rising_q <= 1'b1;
			flash_q          <= '0;
			record_q         <= '0;
			search_q         <= 1'b0;
			marquee_q        <= '0;
			m0_q             <= '0;
			m1_q             <= '0;
		end else if (accept) begin
			flash_q <= flash ? cd - LEVEL_W'(1) : cd;
			if (!flash && recording_on) begin
				record_q <= rec_next;
			end
			if (!flash && !recording_on && track_mode == MODE_SEARCH) begin
				search_q <= search_next;
			end
			if (tick.marquee) begin
				marquee_q <= marquee_q + MARQUEE_W'(1);
				if (marquee_q == {MARQUEE_W{1'b1}}) begin
					m0_q <= '0;
					m1_q <= '0;
				end else begin
					m0_q <= (m0_q == N0M1) ? '0 : m0_q + PIX_IDX_W'(1);
					m1_q <= (m1_q == N1M1) ? '0 : m1_q + PIX_IDX_W'(1);
				end
			end
			if (breathe_rising_q) begin
				if (up_sum < {1'b0, r_max}) begin
					breathe_level_q <= up_sum[LEVEL_W-1:0];
				end else begin
					breathe_level_q  <= r_max;
					breathe_rising_q <= 1'b0;
				end
			end else begin
				if ({1'b0, breathe_level_q} > dn_lim) begin
					breathe_level_q <= breathe_level_q - r_inc;
				end else begin
					breathe_level_q  <= r_min;
					breathe_rising_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/slpg_queue.sv */
// ----------------------------------------------------------------------------
// slpg_queue
// Short queue of frame descriptors between the classifier and the emitter.
// ----------------------------------------------------------------------------
module slpg_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  slpg_pkg::slpg_tick_t wr_data,
	output logic                 full,
	input  logic                 rd_en,
	output logic                 rd_valid,
	output slpg_pkg::slpg_tick_t rd_data
);
	import slpg_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	slpg_tick_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			priority if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end else begin
				count_q <= count_q;
			end
		end
	end

endmodule

/* rtl/slpg_back.sv */
// ----------------------------------------------------------------------------
// slpg_back
// Walks the pixels of chain 0, then of chain 1 when SECOND_CHAIN_PRESENT is set,
// for each frame descriptor and holds one result item in the output register.
// ----------------------------------------------------------------------------
module slpg_back #(
	parameter int CHAIN0_PIXELS        = 8,
	parameter int CHAIN1_PIXELS        = 8,
	parameter int SECOND_CHAIN_PRESENT = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  slpg_pkg::slpg_tick_t           q_data,
	output logic                           q_pop,
	input  logic                           pop,
	output logic                           empty,
	output logic                           chain_select,
	output logic [slpg_pkg::PIX_IDX_W-1:0] pixel_index,
	output logic [slpg_pkg::LEVEL_W-1:0]   red_level,
	output logic [slpg_pkg::LEVEL_W-1:0]   green_level,
	output logic [slpg_pkg::LEVEL_W-1:0]   blue_level,
	output logic [slpg_pkg::LEVEL_W-1:0]   global_brightness,
	output logic                           frame_last
);
	import slpg_pkg::*;

	localparam logic [PIX_IDX_W-1:0] N0M1 = PIX_IDX_W'(CHAIN0_PIXELS - 1);
	localparam logic [PIX_IDX_W-1:0] N1M1 = PIX_IDX_W'(CHAIN1_PIXELS - 1);
	localparam logic LAST_CHAIN = (SECOND_CHAIN_PRESENT != 0) ? 1'b1 : 1'b0;

	slpg_tick_t           cur_q;
	logic                 busy_q;
	logic                 chain_q;
	logic [PIX_IDX_W-1:0] idx_q;
	logic                 ov_q;

	logic                 adv;
	logic                 chain_end;
	logic                 at_end;
	logic                 load;
	logic [PIX_IDX_W-1:0] hd, ta, tb;
	logic [LEVEL_W-1:0]   pr, pg, pb;

	assign adv       = busy_q && (!ov_q || pop);
	assign chain_end = (idx_q == (chain_q ? N1M1 : N0M1));
	assign at_end    = (chain_q == LAST_CHAIN) && chain_end;
	assign load      = q_valid && (!busy_q || (adv && at_end));
	assign q_pop     = load;
	assign empty     = !ov_q;

	assign hd = chain_q ? cur_q.h1 : cur_q.h0;
	assign ta = chain_q ? cur_q.a1 : cur_q.a0;
	assign tb = chain_q ? cur_q.b1 : cur_q.b0;

	always_comb begin
		pr = cur_q.red;
		pg = cur_q.green;
		pb = cur_q.blue;
		if (cur_q.marquee) begin
			pr = LEVEL_OFF;
			pb = LEVEL_OFF;
			priority if (idx_q == hd) begin
				pg = LEVEL_FULL;
			end else if (idx_q == ta) begin
				pg = MARQUEE_MID;
			end else if (idx_q == tb) begin
				pg = MARQUEE_TAIL;
			end else begin
				pg = LEVEL_OFF;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			chain_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			busy_q  <= 1'b1;
			chain_q <= 1'b0;
			idx_q   <= '0;
		end else if (adv) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else if (chain_end) begin
				chain_q <= 1'b1;
				idx_q   <= '0;
			end else begin
				idx_q <= idx_q + PIX_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chain_select      <= chain_q;
			pixel_index       <= idx_q;
			red_level         <= pr;
			green_level       <= pg;
			blue_level        <= pb;
			global_brightness <= cur_q.bright;
			frame_last        <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv) begin
			ov_q <= 1'b1;
		end else if (pop) begin
			ov_q <= 1'b0;
		end
	end

	a_last_on_last_chain : assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && frame_last) |-> (chain_select == LAST_CHAIN))
		else $error("frame end flagged on the wrong chain");

	a_index_in_chain : assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (pixel_index <= (chain_select ? N1M1 : N0M1)))
		else $error("pixel index beyond its chain");

	a_frame_starts_at_zero : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> (idx_q == '0 && chain_q == 1'b0))
		else $error("frame walk did not start at the first pixel");

endmodule

/* rtl/status_led_pattern_generator.sv */
// ----------------------------------------------------------------------------
// status_led_pattern_generator
// Turns animation ticks into per-pixel colour items for two LED chains.
// ----------------------------------------------------------------------------
// A tick item is taken and queued (two entries); each tick then
// yields CHAIN0_PIXELS + CHAIN1_PIXELS result items (CHAIN0_PIXELS alone when
// SECOND_CHAIN_PRESENT is 0), one per cycle while pop keeps up, chain 0 first,
// frame_last on the final one. The pixel walker sets the sustained rate, with no
// gap between frames. Configuration writes are always ready and belong in idle
// periods.
module status_led_pattern_generator #(
	parameter int CHAIN0_PIXELS        = 8,
	parameter int CHAIN1_PIXELS        = 8,
	parameter int SECOND_CHAIN_PRESENT = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [slpg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [slpg_pkg::LEVEL_W-1:0]   cfg_data,
	input  logic                           push,
	output logic                           full,
	input  logic [slpg_pkg::MODE_W-1:0]    track_mode,
	input  logic                           recording_on,
	input  logic                           photo_event,
	input  logic                           pop,
	output logic                           empty,
	output logic                           chain_select,
	output logic [slpg_pkg::PIX_IDX_W-1:0] pixel_index,
	output logic [slpg_pkg::LEVEL_W-1:0]   red_level,
	output logic [slpg_pkg::LEVEL_W-1:0]   green_level,
	output logic [slpg_pkg::LEVEL_W-1:0]   blue_level,
	output logic [slpg_pkg::LEVEL_W-1:0]   global_brightness,
	output logic                           frame_last
);
	import slpg_pkg::*;

	slpg_tick_t tick;
	slpg_tick_t q_data;
	logic       accept;
	logic       q_valid;
	logic       q_pop;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	slpg_front #(
		.CHAIN0_PIXELS(CHAIN0_PIXELS),
		.CHAIN1_PIXELS(CHAIN1_PIXELS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.track_mode  (track_mode),
		.recording_on(recording_on),
		.photo_event (photo_event),
		.tick        (tick)
	);

	slpg_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (tick),
		.full    (full),
		.rd_en   (q_pop),
		.rd_valid(q_valid),
		.rd_data (q_data)
	);

	slpg_back #(
		.CHAIN0_PIXELS       (CHAIN0_PIXELS),
		.CHAIN1_PIXELS       (CHAIN1_PIXELS),
		.SECOND_CHAIN_PRESENT(SECOND_CHAIN_PRESENT)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_data           (q_data),
		.q_pop            (q_pop),
		.pop              (pop),
		.empty            (empty),
		.chain_select     (chain_select),
		.pixel_index      (pixel_index),
		.red_level        (red_level),
		.green_level      (green_level),
		.blue_level       (blue_level),
		.global_brightness(global_brightness),
		.frame_last       (frame_last)
	);

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives animation ticks into the status LED pattern generator and checks
// every pixel item against a cycle-free model of the pattern logic: flash,
// recording blink, breathing, marquee and search blink, under several
// register settings, random gaps on both sides and a long output stall.
// ----------------------------------------------------------------------------
module testbench;
	import slpg_pkg::*;

	localparam int CHAIN0 = 8;
	localparam int CHAIN1 = 8;
	localparam int SECOND = 1;
	localparam int PIXELS = CHAIN0 + (SECOND != 0 ? CHAIN1 : 0);
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 40;
	localparam int MAX_REPORTS = 100;
	localparam int TIMEOUT_NS = 5_000_000;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd15;

	localparam logic [23:0] RGB_WHITE  = {LEVEL_FULL, LEVEL_FULL, LEVEL_FULL};
	localparam logic [23:0] RGB_RED    = {LEVEL_FULL, LEVEL_OFF, LEVEL_OFF};
	localparam logic [23:0] RGB_BLUE   = {LEVEL_OFF, LEVEL_OFF, LEVEL_FULL};
	localparam logic [23:0] RGB_YELLOW = {LEVEL_FULL, LEVEL_FULL, LEVEL_OFF};

	typedef enum logic [2:0] {
		ST_TICK,
		ST_CFG,
		ST_DRAIN,
		ST_RATE,
		ST_HOLD
	} step_kind_e;

	typedef struct {
		step_kind_e           kind;
		logic [MODE_W-1:0]    mode;
		logic                 rec;
		logic                 photo;
		logic [CFG_IDX_W-1:0] idx;
		logic [LEVEL_W-1:0]   data;
		int                   send_pct;
		int                   recv_pct;
	} step_t;

	typedef struct packed {
		logic                 chain;
		logic [PIX_IDX_W-1:0] idx;
		logic [LEVEL_W-1:0]   red;
		logic [LEVEL_W-1:0]   green;
		logic [LEVEL_W-1:0]   blue;
		logic [LEVEL_W-1:0]   bright;
		logic                 last;
	} pixel_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LEVEL_W-1:0]   cfg_data = '0;
	logic                 push = 1'b0;
	logic                 full;
	logic [MODE_W-1:0]    track_mode = '0;
	logic                 recording_on = 1'b0;
	logic                 photo_event = 1'b0;
	logic                 pop = 1'b0;
	logic                 empty;
	logic                 chain_select;
	logic [PIX_IDX_W-1:0] pixel_index;
	logic [LEVEL_W-1:0]   red_level;
	logic [LEVEL_W-1:0]   green_level;
	logic [LEVEL_W-1:0]   blue_level;
	logic [LEVEL_W-1:0]   global_brightness;
	logic                 frame_last;

	step_t  step_plan[$];
	pixel_t pending_pixels[$];
	int     pixel_errors = 0;

	logic tick_taken = 1'b0;
	logic cfg_taken = 1'b0;
	logic hold_kick = 1'b0;
	int   send_pct = 0;
	int   recv_pct = 0;
	int   settle_count = 0;
	int   hold_left = 0;

	logic [LEVEL_W-1:0]     cfg_regs [NUM_REGS];
	logic [LEVEL_W-1:0]     breathe_level;
	logic                   breathe_up;
	logic [LEVEL_W-1:0]     flash_left;
	logic [REC_PHASE_W-1:0] rec_phase;
	logic                   search_on;
	logic [MARQUEE_W-1:0]   sweep_pos;

	status_led_pattern_generator #(
		.CHAIN0_PIXELS(CHAIN0),
		.CHAIN1_PIXELS(CHAIN1),
		.SECOND_CHAIN_PRESENT(SECOND)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.track_mode(track_mode),
		.recording_on(recording_on),
		.photo_event(photo_event),
		.pop(pop),
		.empty(empty),
		.chain_select(chain_select),
		.pixel_index(pixel_index),
		.red_level(red_level),
		.green_level(green_level),
		.blue_level(blue_level),
		.global_brightness(global_brightness),
		.frame_last(frame_last)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		pixel_errors++;
		if (pixel_errors <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic logic [LEVEL_W-1:0] reg_val(input logic [CFG_IDX_W-1:0] idx);
		return cfg_regs[idx[REG_SEL_W-1:0]];
	endfunction

	function automatic logic [23:0] sweep_colour(input int pos, input int head, input int mid,
			input int tail);
		if (pos == head) return {LEVEL_OFF, LEVEL_FULL, LEVEL_OFF};
		if (pos == mid) return {LEVEL_OFF, MARQUEE_MID, LEVEL_OFF};
		if (pos == tail) return {LEVEL_OFF, MARQUEE_TAIL, LEVEL_OFF};
		return '0;
	endfunction

	task automatic render_tick(input logic [MODE_W-1:0] mode, input logic rec,
			input logic photo);
		logic [23:0]        rgb;
		logic [LEVEL_W-1:0] bright;
		logic               sweep;
		int                 h0, a0, b0, h1, a1, b1, k, pos;
		pixel_t             px;
		rgb = RGB_BLUE;
		bright = breathe_level;
		sweep = 1'b0;
		if (photo) flash_left = reg_val(REG_FLASH_TICKS);
		if (flash_left != 0) begin
			flash_left = flash_left - 1'b1;
			rgb = RGB_WHITE;
			bright = reg_val(REG_FLASH_BRIGHT);
		end else if (rec) begin
			rgb = RGB_RED;
			rec_phase = rec_phase + 1'b1;
			if (rec_phase <= 1 || (rec_phase >= 4 && rec_phase <= 5))
				bright = reg_val(REG_REC_BRIGHT);
			else
				bright = reg_val(REG_REC_DIM);
		end else begin
			case (mode)
				MODE_IDLE: begin
					rgb = RGB_BLUE;
					bright = breathe_level;
				end
				MODE_TRACKING: begin
					bright = reg_val(REG_NORMAL_BRIGHT);
					sweep = 1'b1;
				end
				MODE_LOCK: begin
					rgb = RGB_YELLOW;
					bright = reg_val(REG_NORMAL_BRIGHT);
				end
				MODE_SEARCH: begin
					rgb = RGB_RED;
					search_on = ~search_on;
					bright = search_on ? reg_val(REG_NORMAL_BRIGHT) : reg_val(REG_BREATHE_MIN);
				end
				default: begin
					rgb = RGB_BLUE;
					bright = reg_val(REG_NORMAL_BRIGHT);
				end
			endcase
		end

		h0 = int'(sweep_pos) % CHAIN0;
		a0 = (h0 + CHAIN0 - 1) % CHAIN0;
		b0 = (h0 + CHAIN0 - 2) % CHAIN0;
		h1 = (CHAIN1 - 1 - (int'(sweep_pos) % CHAIN1)) % CHAIN1;
		a1 = (h1 + 1) % CHAIN1;
		b1 = (h1 + 2) % CHAIN1;

		for (k = 0; k < PIXELS; k++) begin
			px.chain = (k >= CHAIN0);
			pos = px.chain ? k - CHAIN0 : k;
			px.idx = PIX_IDX_W'(pos);
			if (!sweep)
				{px.red, px.green, px.blue} = rgb;
			else if (px.chain)
				{px.red, px.green, px.blue} = sweep_colour(pos, h1, a1, b1);
			else
				{px.red, px.green, px.blue} = sweep_colour(pos, h0, a0, b0);
			px.bright = bright;
			px.last = (k == PIXELS - 1);
			pending_pixels.push_back(px);
		end

		if (sweep) sweep_pos = sweep_pos + 1'b1;

		if (breathe_up) begin
			if ({1'b0, breathe_level} + {1'b0, reg_val(REG_BREATHE_INC)} <
					{1'b0, reg_val(REG_BREATHE_MAX)}) begin
				breathe_level = breathe_level + reg_val(REG_BREATHE_INC);
			end else begin
				breathe_level = reg_val(REG_BREATHE_MAX);
				breathe_up = 1'b0;
			end
		end else begin
			if ({1'b0, breathe_level} >
					{1'b0, reg_val(REG_BREATHE_MIN)} + {1'b0, reg_val(REG_BREATHE_INC)}) begin
				breathe_level = breathe_level - reg_val(REG_BREATHE_INC);
			end else begin
				breathe_level = reg_val(REG_BREATHE_MIN);
				breathe_up = 1'b1;
			end
		end
	endtask

	task automatic add_tick(input int mode, input bit rec, input bit photo);
		step_t s;
		s = '{kind: ST_TICK, default: 0};
		s.mode = MODE_W'(mode);
		s.rec = rec;
		s.photo = photo;
		step_plan.push_back(s);
	endtask

	task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] data);
		step_t s;
		s = '{kind: ST_CFG, default: 0};
		s.idx = idx;
		s.data = data;
		step_plan.push_back(s);
	endtask

	task automatic add_ctrl(input step_kind_e kind, input int snd = 0, input int rcv = 0);
		step_t s;
		s = '{kind: kind, default: 0};
		s.send_pct = snd;
		s.recv_pct = rcv;
		step_plan.push_back(s);
	endtask

	task automatic load_regs(input logic [LEVEL_W-1:0] vals [NUM_REGS]);
		add_ctrl(ST_DRAIN);
		for (int i = 0; i < NUM_REGS; i++)
			add_cfg(CFG_IDX_W'(i), vals[i]);
	endtask

	// runs of one mode and recording state, with rare photo events and some noise
	task automatic add_random_run(input int count);
		int  left, run_len, mode;
		bit  rec;
		left = count;
		while (left > 0) begin
			run_len = $urandom_range(12, 1);
			mode = ($urandom_range(99) < 85) ? $urandom_range(3) : $urandom_range(7, 4);
			rec = ($urandom_range(99) < 25);
			for (int j = 0; j < run_len && left > 0; j++) begin
				if ($urandom_range(99) < 10)
					add_tick($urandom_range(7), 1'($urandom_range(1)),
						$urandom_range(99) < 4);
				else
					add_tick(mode, rec, $urandom_range(99) < 4);
				left--;
			end
		end
	endtask

	always @(posedge clk) begin : monitor
		pixel_t got;
		pixel_t want;
		tick_taken <= arst_n && push && !full;
		cfg_taken <= arst_n && cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
				cfg_regs[cfg_index[REG_SEL_W-1:0]] = cfg_data;
			if (push && !full)
				render_tick(track_mode, recording_on, photo_event);
			if (pop && !empty) begin
				got = {chain_select, pixel_index, red_level, green_level, blue_level,
					global_brightness, frame_last};
				if (pending_pixels.size() == 0) begin
					report_mismatch($sformatf("unexpected pixel chain %0d index %0d",
						chain_select, pixel_index));
				end else begin
					want = pending_pixels.pop_front();
					if (got !== want)
						report_mismatch($sformatf(
							"got c%0d i%0d rgb %h %h %h b%0d l%0b, want c%0d i%0d rgb %h %h %h b%0d l%0b",
							got.chain, got.idx, got.red, got.green, got.blue, got.bright, got.last,
							want.chain, want.idx, want.red, want.green, want.blue, want.bright,
							want.last));
				end
			end
		end
	end

	always @(negedge clk) begin : sender
		step_t head;
		logic  offer;
		logic  cfg_offer;
		logic  kick;
		offer = 1'b0;
		cfg_offer = 1'b0;
		kick = 1'b0;
		if (arst_n) begin
			if ((tick_taken || cfg_taken) && step_plan.size() != 0)
				head = step_plan.pop_front();
			while (step_plan.size() != 0 &&
					(step_plan[0].kind == ST_RATE || step_plan[0].kind == ST_HOLD)) begin
				head = step_plan.pop_front();
				if (head.kind == ST_RATE) begin
					send_pct = head.send_pct;
					recv_pct <= head.recv_pct;
				end else begin
					kick = 1'b1;
				end
			end
			if (step_plan.size() != 0) begin
				head = step_plan[0];
				case (head.kind)
					ST_TICK: begin
						if (push && !tick_taken)
							offer = 1'b1;
						else
							offer = ($urandom_range(99) >= send_pct);
						if (offer) begin
							track_mode <= head.mode;
							recording_on <= head.rec;
							photo_event <= head.photo;
						end
					end
					ST_CFG: begin
						cfg_offer = 1'b1;
						cfg_index <= head.idx;
						cfg_data <= head.data;
					end
					ST_DRAIN: begin
						if (pending_pixels.size() != 0) begin
							settle_count = 0;
						end else if (settle_count >= SETTLE_CYCLES) begin
							settle_count = 0;
							head = step_plan.pop_front();
						end else begin
							settle_count++;
						end
					end
					default: begin
					end
				endcase
			end
		end
		push <= offer;
		cfg_valid <= cfg_offer;
		hold_kick <= kick;
	end

	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (hold_kick) begin
				hold_left = HOLD_CYCLES;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_pct);
			end
		end
	end

	initial begin
		logic [LEVEL_W-1:0] vals [NUM_REGS];
		foreach (cfg_regs[i]) cfg_regs[i] = REG_RESET[i];
		breathe_level = REG_RESET[REG_SEL_W'(REG_BREATHE_MIN)];
		breathe_up = 1'b1;
		flash_left = '0;
		rec_phase = '0;
		search_on = 1'b0;
		sweep_pos = '0;

		add_ctrl(ST_RATE, 10, 72);
		add_tick(MODE_IDLE, 0, 0);
		add_tick(MODE_IDLE, 0, 0);
		add_tick(MODE_IDLE, 0, 0);
		add_tick(MODE_TRACKING, 0, 0);
		add_tick(MODE_TRACKING, 0, 0);
		add_tick(MODE_TRACKING, 0, 0);
		add_tick(MODE_LOCK, 0, 0);
		add_tick(MODE_SEARCH, 0, 0);
		add_tick(MODE_SEARCH, 0, 0);
		add_tick(4, 0, 0);
		add_tick(7, 0, 0);
		add_tick(MODE_IDLE, 1, 0);
		add_tick(MODE_TRACKING, 1, 0);
		add_tick(MODE_SEARCH, 1, 0);
		add_tick(6, 1, 0);
		add_tick(MODE_LOCK, 0, 1);
		add_tick(MODE_TRACKING, 1, 0);
		add_tick(MODE_SEARCH, 0, 0);
		add_tick(MODE_IDLE, 0, 0);
		add_tick(MODE_TRACKING, 0, 0);
		add_tick(MODE_TRACKING, 0, 0);
		add_tick(5, 1, 1);
		// zero-length flash
		add_ctrl(ST_DRAIN);
		add_cfg(REG_FLASH_TICKS, 8'd0);
		add_tick(6, 0, 1);
		add_tick(MODE_TRACKING, 1, 1);

		vals = '{8'd0, 8'd255, 8'd1, 8'd255, 8'd255, 8'd255, 8'd0, 8'd1};
		load_regs(vals);
		add_ctrl(ST_HOLD);
		add_random_run(90);

		add_ctrl(ST_DRAIN);
		add_ctrl(ST_RATE, 72, 10);
		vals = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0};
		load_regs(vals);
		add_cfg(CFG_IDX_SPARE, 8'hA5);
		add_random_run(90);

		add_ctrl(ST_DRAIN);
		add_ctrl(ST_RATE, 0, 0);
		foreach (vals[i]) vals[i] = LEVEL_W'($urandom_range(255));
		vals[REG_SEL_W'(REG_FLASH_TICKS)] = LEVEL_W'($urandom_range(8));
		load_regs(vals);
		add_random_run(90);

		vals = '{8'd200, 8'd100, 8'd0, 8'd128, 8'd1, 8'd1, 8'd254, 8'd255};
		load_regs(vals);
		add_random_run(90);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (step_plan.size() != 0 || pending_pixels.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pixel_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAILURE");
		$finish;
	end

endmodule
